// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the linked list manager controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on the rising clock edge, switched off while reset is active.
`define IDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define IDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IDM_ASSERT(lbl, prop, msg)
`define IDM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/idm_pkg.sv -----
// Types, codes and constants shared by the linked list manager modules.
package idm_pkg;

  // Pool geometry.
  localparam int unsigned POOL_DEPTH_DEF = 1024;
  localparam int unsigned ROOT_INDEX     = 0;

  // Field widths of the stream payloads.
  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  // Request action codes.
  typedef logic [ACTION_W-1:0] action_t;
  localparam action_t ACT_ADD_HEAD  = 3'd0;
  localparam action_t ACT_ADD_TAIL  = 3'd1;
  localparam action_t ACT_MOVE_HEAD = 3'd2;
  localparam action_t ACT_MOVE_TAIL = 3'd3;
  localparam action_t ACT_REMOVE    = 3'd4;

  // Link write steps: two to take an entry out, two to put it in.
  typedef logic [1:0] wr_step_t;
  localparam wr_step_t STEP_UNLINK_A = 2'd0;
  localparam wr_step_t STEP_UNLINK_B = 2'd1;
  localparam wr_step_t STEP_LINK_A   = 2'd2;
  localparam wr_step_t STEP_LINK_B   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     clr;       // write one entry of the clearing pass
    logic     capture;   // load the accepted request
    logic     eval;      // read data valid, latch links and decision
    logic     wr_en;     // perform one link write step
    wr_step_t wr_step;   // which link write step
    logic     load_out;  // load the result register
  } idm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pass is at its final entry
    logic go;        // guards of the current request pass
    logic unlink;    // action takes the entry out of the list
    logic link;      // action puts the entry into the list
    logic out_free;  // result register can take a new result
  } idm_status_t;

endpackage

// ----- rtl/core/indexed_dlist_manager_top.sv -----
// Top level of the indexed circular doubly linked list manager.
// The block keeps a circular doubly linked list over a pool of POOL_DEPTH entries,
// with entry 0 as the root, and applies one request (add at head or tail, move to
// head or tail, remove) at a time, returning one result per request: whether the
// list changed, whether it is empty, and its head and tail afterwards. After reset
// a clearing pass over all POOL_DEPTH entries makes every entry point to itself; no
// request is accepted during it. A refused request passes the read, evaluate and
// done states; an add also passes the link steps, a remove the unlink steps and a
// move both: the entry's links are read through the registered read port of the
// link memories, and the link changes are made one step at a time because each of
// the two link memories has one write port. A finished result waits in an output
// register, so the next request is taken while it is still pending.
module indexed_dlist_manager_top #(
  parameter int unsigned POOL_DEPTH = idm_pkg::POOL_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] action, [12:3] entry_index, [15:13] zero.
  input  logic [idm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] applied, [1] list_empty, [11:2] head_entry, [21:12] tail_entry, [23:22] zero.
  output logic [idm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import idm_pkg::*;

  idm_cmd_t    cmd;
  idm_status_t status;

  // Sequencing of requests.
  idm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // Link storage and result.
  idm_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- rtl/core/idm_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module idm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read of the address being written returns old data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/idm_datapath.sv -----
// Datapath of the linked list manager: link memories, root links, guards and result.
module idm_datapath #(
  parameter int unsigned POOL_DEPTH = idm_pkg::POOL_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request payload: [2:0] action, [12:3] entry_index.
  input  logic [idm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  idm_pkg::idm_cmd_t                cmd_i,
  output idm_pkg::idm_status_t             status_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // Result payload: [0] applied, [1] list_empty, [11:2] head_entry, [21:12] tail_entry.
  output logic [idm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  import idm_pkg::*;

  localparam int unsigned LW = $clog2(POOL_DEPTH);
  localparam logic [LW-1:0] ROOT_L = LW'(ROOT_INDEX);
  localparam logic [LW-1:0] LAST_L = LW'(POOL_DEPTH - 1);

  logic [ACTION_W-1:0] in_action;
  logic [INDEX_W-1:0]  in_index;

  action_t   act_q;
  logic [LW-1:0] e_q, p_q, n_q, before_q;
  logic      idx_ok_q;
  logic [LW-1:0] clr_q;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d;
  logic      applied_q;

  logic [LW-1:0] prev_rd, next_rd;
  logic      pw_en, nw_en;
  logic [LW-1:0] pw_addr, pw_data, nw_addr, nw_data;

  logic      to_head;
  logic [LW-1:0] after_now, before_now;
  logic      unlinked, linked, movable, guard;
  logic      unlink_act, link_act;

  logic      out_valid_q;
  logic      out_applied_q, out_empty_q;
  logic [INDEX_W-1:0] out_head_q, out_tail_q;

  assign in_action = s_axis_tdata_i[ACTION_W-1:0];
  assign in_index  = s_axis_tdata_i[ACTION_W+INDEX_W-1:ACTION_W];

  // Request capture with the range and root check of the index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q    <= in_action;
      e_q      <= LW'(in_index);
      idx_ok_q <= (32'(in_index) < 32'(POOL_DEPTH)) && (32'(in_index) != 32'(ROOT_INDEX));
    end
    if (cmd_i.eval) begin
      p_q <= prev_rd;
      n_q <= next_rd;
    end
    if (cmd_i.wr_en && (cmd_i.wr_step == STEP_LINK_A)) begin
      before_q <= before_now;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr && (clr_q != LAST_L)) begin
      clr_q <= clr_q + LW'(1);
    end
  end

  // Action classes.
  always_comb begin
    unlink_act = 1'b0;
    link_act   = 1'b0;
    case (act_q) inside
      ACT_ADD_HEAD, ACT_ADD_TAIL: begin
        link_act = 1'b1;
      end
      ACT_MOVE_HEAD, ACT_MOVE_TAIL: begin
        unlink_act = 1'b1;
        link_act   = 1'b1;
      end
      ACT_REMOVE: begin
        unlink_act = 1'b1;
      end
      default: begin
        unlink_act = 1'b0;
        link_act   = 1'b0;
      end
    endcase
  end

  // Guards, evaluated on the links just read for the entry.
  assign unlinked = (prev_rd == e_q) && (next_rd == e_q);
  assign linked   = (prev_rd != e_q) && (next_rd != e_q);
  assign movable  = linked && (next_rd != prev_rd);

  always_comb begin
    guard = 1'b0;
    case (act_q)
      ACT_ADD_HEAD:  guard = unlinked && (prev_rd != ROOT_L);
      ACT_ADD_TAIL:  guard = unlinked && (next_rd != ROOT_L);
      ACT_MOVE_HEAD: guard = movable && (prev_rd != ROOT_L);
      ACT_MOVE_TAIL: guard = movable && (next_rd != ROOT_L);
      ACT_REMOVE:    guard = linked;
      default:       guard = 1'b0;
    endcase
  end

  // Neighbors of the entry when it is put at the head or at the tail.
  assign to_head    = (act_q == ACT_ADD_HEAD) || (act_q == ACT_MOVE_HEAD);
  assign after_now  = to_head ? head_q : ROOT_L;
  assign before_now = to_head ? ROOT_L : tail_q;

  // Link write selection for the clearing pass and the four write steps.
  always_comb begin
    pw_en   = cmd_i.clr || cmd_i.wr_en;
    nw_en   = cmd_i.clr || cmd_i.wr_en;
    pw_addr = clr_q;
    pw_data = clr_q;
    nw_addr = clr_q;
    nw_data = clr_q;
    if (cmd_i.wr_en) begin
      unique case (cmd_i.wr_step)
        STEP_UNLINK_A: begin
          pw_addr = n_q;
          pw_data = p_q;
          nw_addr = p_q;
          nw_data = n_q;
        end
        STEP_UNLINK_B: begin
          pw_addr = e_q;
          pw_data = e_q;
          nw_addr = e_q;
          nw_data = e_q;
        end
        STEP_LINK_A: begin
          pw_addr = after_now;
          pw_data = e_q;
          nw_addr = e_q;
          nw_data = after_now;
        end
        STEP_LINK_B: begin
          pw_addr = e_q;
          pw_data = before_q;
          nw_addr = before_q;
          nw_data = e_q;
        end
        default: begin
          pw_addr = clr_q;
          pw_data = clr_q;
          nw_addr = clr_q;
          nw_data = clr_q;
        end
      endcase
    end
  end

  // The root's links live in registers and follow every write to the root.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (nw_en && (nw_addr == ROOT_L)) begin
      head_d = nw_data;
    end
    if (pw_en && (pw_addr == ROOT_L)) begin
      tail_d = pw_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= ROOT_L;
      tail_q <= ROOT_L;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Link memories.
  idm_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_DEPTH)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (pw_en),
    .waddr_i (pw_addr),
    .wdata_i (pw_data),
    .raddr_i (e_q),
    .rdata_o (prev_rd)
  );

  idm_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_DEPTH)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nw_en),
    .waddr_i (nw_addr),
    .wdata_i (nw_data),
    .raddr_i (e_q),
    .rdata_o (next_rd)
  );

  // Decision of the current request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      applied_q <= guard && idx_ok_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_applied_q <= applied_q;
      out_empty_q   <= (head_q == ROOT_L);
      out_head_q    <= INDEX_W'(head_q);
      out_tail_q    <= INDEX_W'(tail_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_tail_q, out_head_q, out_empty_q, out_applied_q};

  // Status toward the controller.
  assign status_o.clr_last = (clr_q == LAST_L);
  assign status_o.go       = guard && idx_ok_q;
  assign status_o.unlink   = unlink_act;
  assign status_o.link     = link_act;
  assign status_o.out_free = !out_valid_q || m_axis_tready_i;

endmodule

// ----- rtl/core/idm_ctrl.sv -----
// Controller state machine of the linked list manager.
`include "assert_macros.svh"

module idm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output idm_pkg::idm_cmd_t    cmd_o,
  input  idm_pkg::idm_status_t status_i
);

  import idm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_W1    = 4'd4;
  localparam logic [3:0] S_W2    = 4'd5;
  localparam logic [3:0] S_W3    = 4'd6;
  localparam logic [3:0] S_W4    = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.clr      = 1'b0;
    cmd_o.capture  = 1'b0;
    cmd_o.eval     = 1'b0;
    cmd_o.wr_en    = 1'b0;
    cmd_o.wr_step  = STEP_UNLINK_A;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!status_i.go) begin
          state_d = S_DONE;
        end else if (status_i.unlink) begin
          state_d = S_W1;
        end else begin
          state_d = S_W3;
        end
      end
      S_W1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_step = STEP_UNLINK_A;
        state_d       = S_W2;
      end
      S_W2: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_step = STEP_UNLINK_B;
        state_d       = status_i.link ? S_W3 : S_DONE;
      end
      S_W3: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_step = STEP_LINK_A;
        state_d       = S_W4;
      end
      S_W4: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_step = STEP_LINK_B;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks on the sequencing.
  `IDM_ASSERT(a_ready_drops, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `IDM_ASSERT(a_load_free, cmd_o.load_out |-> status_i.out_free, "result overwritten")
  `IDM_ASSERT(a_w4_after_w3, (state_q == S_W4) |-> ($past(state_q) == S_W3), "bad link order")
  `IDM_ASSERT(a_eval_after_read, cmd_o.eval |-> ($past(state_q) == S_READ), "eval without read")
  `IDM_ASSERT(a_clear_ends, (state_q == S_CLEAR && status_i.clr_last) |=> (state_q == S_IDLE), "clear pass stuck")

endmodule
